// ===== rtl/core/mvpa_pkg.sv =====
// Shared types, widths and constants for the mesh volume and projected area unit.
package mvpa_pkg;

    // Coordinate fields are signed Q7.8
    localparam int COORD_W       = 16;
    localparam int PROD_W        = 2 * COORD_W;        // pairwise product
    localparam int PDIFF_W       = PROD_W + 1;         // difference of two products
    localparam int TRIPLE_W      = PDIFF_W + COORD_W;  // one cofactor term
    localparam int DET_W         = TRIPLE_W + 2;       // sum of three cofactor terms
    localparam int EDGE_W        = COORD_W + 1;        // vertex difference
    localparam int EDGE_PROD_W   = 2 * EDGE_W;         // product of an edge by an edge
    localparam int NZ_W          = EDGE_PROD_W + 1;    // cross product z part, signed
    localparam int AREA_TERM_W   = NZ_W - 1;           // positive cross z part

    // Running sums
    localparam int VOL_W         = 62;
    localparam int AREA_W        = 48;
    localparam logic signed [VOL_W-1:0] VOL_MAX = {1'b0, {(VOL_W-1){1'b1}}};
    localparam logic signed [VOL_W-1:0] VOL_MIN = {1'b1, {(VOL_W-1){1'b0}}};

    // Result fields
    localparam int MESH_VOL_W    = 60;
    localparam int PROJ_AREA_W   = 47;

    // Divide by six: multiply the magnitude by ceil(2^65 / 3) in shift-add
    // steps, one a cycle, and keep the product from bit DIV_SHIFT up
    localparam int DIV_W         = 128;
    localparam int DIV_CYCLES    = 6;
    localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);
    localparam int DIV_SHIFT     = 66;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic signed [COORD_W-1:0] p0_x;
        logic signed [COORD_W-1:0] p0_y;
        logic signed [COORD_W-1:0] p0_z;
        logic signed [COORD_W-1:0] p1_x;
        logic signed [COORD_W-1:0] p1_y;
        logic signed [COORD_W-1:0] p1_z;
        logic signed [COORD_W-1:0] p2_x;
        logic signed [COORD_W-1:0] p2_y;
        logic signed [COORD_W-1:0] p2_z;
        logic                      final_triangle;
    } t_tri;

    typedef struct packed {
        logic [MESH_VOL_W-1:0]  mesh_volume;
        logic [PROJ_AREA_W-1:0] projected_area;
        logic                   saturated;
    } t_res;

    // One classified triangle, as queued between front and back
    typedef struct packed {
        logic signed [DET_W-1:0] det;
        logic [AREA_TERM_W-1:0]  area;
        logic                    last;
    } t_term;

endpackage

// ===== rtl/core/mvpa_if.sv =====
// Valid/ready channel interfaces for triangles and results.
interface mvpa_tri_if import mvpa_pkg::*; ();
    logic valid;
    logic ready;
    t_tri payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mvpa_res_if import mvpa_pkg::*; ();
    logic valid;
    logic ready;
    t_res payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/mvpa_front.sv =====
// Front part: accept triangles and reduce them to a determinant and an area term.
module mvpa_front import mvpa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mvpa_tri_if.sink   i_tri,
    output logic       o_push,
    output t_term      o_push_data,
    input  logic       i_full
);

    typedef struct packed {
        logic signed [PROD_W-1:0]  m0;
        logic signed [PROD_W-1:0]  m1;
        logic signed [PROD_W-1:0]  m2;
        logic signed [PROD_W-1:0]  m3;
        logic signed [PROD_W-1:0]  m4;
        logic signed [PROD_W-1:0]  m5;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] cy;
        logic signed [EDGE_W-1:0]  dx1;
        logic signed [EDGE_W-1:0]  dy1;
        logic signed [EDGE_W-1:0]  dx2;
        logic signed [EDGE_W-1:0]  dy2;
        logic                      last;
    } t_s1;

    typedef struct packed {
        logic signed [TRIPLE_W-1:0]    t0;
        logic signed [TRIPLE_W-1:0]    t1;
        logic signed [TRIPLE_W-1:0]    t2;
        logic signed [EDGE_PROD_W-1:0] q0;
        logic signed [EDGE_PROD_W-1:0] q1;
        logic                          last;
    } t_s2;

    logic  r_v1, r_v2, r_v3;
    t_s1   r_s1, n_s1;
    t_s2   r_s2, n_s2;
    t_term r_s3, n_s3;
    logic  en1, en2, en3;

    // Each stage moves on when it is empty or the stage after it moves
    assign en3         = !r_v3 || !i_full;
    assign en2         = !r_v2 || en3;
    assign en1         = !r_v1 || en2;
    assign i_tri.ready = en1;
    assign o_push      = r_v3;
    assign o_push_data = r_s3;

    // Stage 1: pairwise products and edge vectors
    always_comb begin
        n_s1.m0   = i_tri.payload.p0_x * i_tri.payload.p2_z;
        n_s1.m1   = i_tri.payload.p0_z * i_tri.payload.p2_x;
        n_s1.m2   = i_tri.payload.p1_x * i_tri.payload.p0_z;
        n_s1.m3   = i_tri.payload.p1_z * i_tri.payload.p0_x;
        n_s1.m4   = i_tri.payload.p2_x * i_tri.payload.p1_z;
        n_s1.m5   = i_tri.payload.p2_z * i_tri.payload.p1_x;
        n_s1.ay   = i_tri.payload.p0_y;
        n_s1.by   = i_tri.payload.p1_y;
        n_s1.cy   = i_tri.payload.p2_y;
        n_s1.dx1  = {i_tri.payload.p1_x[COORD_W-1], i_tri.payload.p1_x}
                  - {i_tri.payload.p0_x[COORD_W-1], i_tri.payload.p0_x};
        n_s1.dy1  = {i_tri.payload.p1_y[COORD_W-1], i_tri.payload.p1_y}
                  - {i_tri.payload.p0_y[COORD_W-1], i_tri.payload.p0_y};
        n_s1.dx2  = {i_tri.payload.p2_x[COORD_W-1], i_tri.payload.p2_x}
                  - {i_tri.payload.p0_x[COORD_W-1], i_tri.payload.p0_x};
        n_s1.dy2  = {i_tri.payload.p2_y[COORD_W-1], i_tri.payload.p2_y}
                  - {i_tri.payload.p0_y[COORD_W-1], i_tri.payload.p0_y};
        n_s1.last = i_tri.payload.final_triangle;
    end

    // Stage 2: cofactor differences times the remaining y, and edge products
    always_comb begin
        logic signed [PDIFF_W-1:0] d0, d1, d2;
        d0 = PDIFF_W'(r_s1.m0) - PDIFF_W'(r_s1.m1);
        d1 = PDIFF_W'(r_s1.m2) - PDIFF_W'(r_s1.m3);
        d2 = PDIFF_W'(r_s1.m4) - PDIFF_W'(r_s1.m5);
        n_s2.t0   = d0 * r_s1.by;
        n_s2.t1   = d1 * r_s1.cy;
        n_s2.t2   = d2 * r_s1.ay;
        n_s2.q0   = r_s1.dx1 * r_s1.dy2;
        n_s2.q1   = r_s1.dy1 * r_s1.dx2;
        n_s2.last = r_s1.last;
    end

    // Stage 3: determinant, and keep the cross z part only when positive
    always_comb begin
        logic signed [NZ_W-1:0] nz;
        nz = NZ_W'(r_s2.q0) - NZ_W'(r_s2.q1);
        n_s3.det  = DET_W'(r_s2.t0) + DET_W'(r_s2.t1) + DET_W'(r_s2.t2);
        n_s3.area = (!nz[NZ_W-1] && (nz != '0)) ? nz[AREA_TERM_W-1:0] : '0;
        n_s3.last = r_s2.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_tri.valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) r_s1 <= n_s1;
        if (en2) r_s2 <= n_s2;
        if (en3) r_s3 <= n_s3;
    end

endmodule

// ===== rtl/core/mvpa_queue.sv =====
// Short queue of classified triangles between front and back.
module mvpa_queue import mvpa_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_term i_push_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_term o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_term             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              push_ok, pop_ok;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (pop_ok)  r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            case ({push_ok, pop_ok})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) r_mem[r_wr] <= i_push_data;
    end

endmodule

// ===== rtl/core/mvpa_back.sv =====
// Back part: saturating sums, divide by six on the last triangle, result register.
module mvpa_back import mvpa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_term       i_q_data,
    output logic        o_pop,
    mvpa_res_if.source  o_res
);

    typedef enum logic [1:0] {
        S_RUN,
        S_ABS,
        S_DIV,
        S_EMIT
    } t_state;

    t_state                   r_state, n_state;
    logic signed [VOL_W-1:0]  r_vol, n_vol;
    logic [AREA_W-1:0]        r_area, n_area;
    logic                     r_ovf, n_ovf;
    logic [DIV_CNT_W-1:0]     r_cnt, n_cnt;
    logic [DIV_W-1:0]         r_div, n_div;
    logic [VOL_W-1:0]         r_mag, n_mag;
    logic [PROJ_AREA_W-1:0]   r_area_hold, n_area_hold;
    logic                     r_ovf_hold, n_ovf_hold;
    logic                     r_out_valid, n_out_valid;
    t_res                     r_out, n_out;

    assign o_pop         = (r_state == S_RUN) && i_q_valid;
    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    always_comb begin
        logic signed [VOL_W:0]  s;
        logic [AREA_W:0]        a;
        logic [VOL_W-1:0]       mag;
        logic [DIV_W-1:0]       dv;

        n_state     = r_state;
        n_vol       = r_vol;
        n_area      = r_area;
        n_ovf       = r_ovf;
        n_cnt       = r_cnt;
        n_div       = r_div;
        n_mag       = r_mag;
        n_area_hold = r_area_hold;
        n_ovf_hold  = r_ovf_hold;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        s   = (VOL_W + 1)'(r_vol) + (VOL_W + 1)'(i_q_data.det);
        a   = {1'b0, r_area} + (AREA_W + 1)'(i_q_data.area);
        mag = r_vol[VOL_W-1] ? VOL_W'(-r_vol) : VOL_W'(r_vol);

        // Build x * 0x5555...5 by doubling the run of ones each step,
        // then finish with x * 0xAAAA...AB = 2 * (x * 0x5555...5) + x
        if (r_cnt == DIV_CNT_W'(DIV_CYCLES - 1))
            dv = {r_div[DIV_W-2:0], 1'b0} + DIV_W'(r_mag);
        else
            dv = r_div + (r_div << (2 << r_cnt));

        // Drop the result once taken
        if (r_out_valid && o_res.ready) n_out_valid = 1'b0;

        case (r_state)
            S_RUN: begin
                if (i_q_valid) begin
                    if (s[VOL_W] != s[VOL_W-1]) begin
                        n_vol = s[VOL_W] ? VOL_MIN : VOL_MAX;
                        n_ovf = 1'b1;
                    end else begin
                        n_vol = s[VOL_W-1:0];
                    end
                    if (a[AREA_W]) begin
                        n_area = '1;
                        n_ovf  = 1'b1;
                    end else begin
                        n_area = a[AREA_W-1:0];
                    end
                    if (i_q_data.last) n_state = S_ABS;
                end
            end
            S_ABS: begin
                n_div       = DIV_W'(mag);
                n_mag       = mag;
                n_cnt       = '0;
                n_area_hold = r_area[AREA_W-1:1];
                n_ovf_hold  = r_ovf;
                n_vol       = '0;
                n_area      = '0;
                n_ovf       = 1'b0;
                n_state     = S_DIV;
            end
            S_DIV: begin
                n_div = dv;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out.mesh_volume    = r_div[DIV_SHIFT +: MESH_VOL_W];
                    n_out.projected_area = r_area_hold;
                    n_out.saturated      = r_ovf_hold;
                    n_out_valid          = 1'b1;
                    n_state              = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_vol       <= '0;
            r_area      <= '0;
            r_ovf       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vol       <= n_vol;
            r_area      <= n_area;
            r_ovf       <= n_ovf;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_div       <= n_div;
        r_mag       <= n_mag;
        r_area_hold <= n_area_hold;
        r_ovf_hold  <= n_ovf_hold;
        r_out       <= n_out;
    end

endmodule

// ===== rtl/core/mesh_volume_and_projected_area_unit.sv =====
// Top level of the mesh volume and projected area unit.
//
//  Channel   Dir  Modport  Payload  Transfer when
//  i_tri     in   sink     t_tri    i_tri.valid && i_tri.ready
//  o_res     out  source   t_res    o_res.valid && o_res.ready
//
// The front takes one triangle per cycle through a three-stage product pipeline
// while the queue has room; the back retires one queued triangle per cycle while
// it accumulates. A triangle flagged last stops the back popping while it takes
// the magnitude, runs the shift-add divide by six and loads the result when the
// result register is free; up to QUEUE_DEPTH + 3 triangles wait behind it before
// the input stalls.
// Reset is synchronous and active low; it clears both sums, the saturation flag,
// all pipeline and queue occupancy and the result valid.
// A stalled result holds in its register while the next mesh keeps accumulating.
module mesh_volume_and_projected_area_unit import mvpa_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mvpa_tri_if.sink    i_tri,
    mvpa_res_if.source  o_res
);

    logic  push, full, pop, q_valid;
    t_term push_data, q_data;

    // Front: form the determinant and the positive cross z part of each triangle
    mvpa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tri       (i_tri),
        .o_push      (push),
        .o_push_data (push_data),
        .i_full      (full)
    );

    // Queue: decouple the pipeline from the accumulator
    mvpa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .i_pop       (pop),
        .o_valid     (q_valid),
        .o_data      (q_data)
    );

    // Back: accumulate with saturation and emit per mesh
    mvpa_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_pop     (pop),
        .o_res     (o_res)
    );

endmodule

// ===== rtl/core/mvpa_checker.sv =====
// Port-level checks on the mesh volume and projected area unit, with its bind.
module mvpa_checker import mvpa_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_tri_ready,
    input logic i_res_valid,
    input logic i_res_ready,
    input t_res i_res_payload
);

    // Hold a stalled result
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> $stable(i_res_payload))
        else $error("result changed while stalled");

    // Reset empties the result register and the front pipeline
    a_reset_res: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_tri_ready)
        else $error("triangle channel not ready after reset");

    // The clamped volume over six never reaches the top bit
    a_vol_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !i_res_payload.mesh_volume[MESH_VOL_W-1])
        else $error("mesh volume out of range");

endmodule

bind mesh_volume_and_projected_area_unit mvpa_checker u_mvpa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_tri_ready   (i_tri.ready),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_res_payload (o_res.payload)
);

// ===== tb/mesh_volume_and_projected_area_unit_tb.sv =====
// Self-checking testbench for the mesh volume and projected area unit.
`timescale 1ns / 1ps

module mesh_volume_and_projected_area_unit_tb;
    import mvpa_pkg::*;

    // Timing and run shape
    localparam int STALL_LIMIT   = 5000;   // cycles with no transfer before giving up
    localparam int LONG_HOLD     = 400;    // receiver hold-off under pressure
    localparam int RANDOM_ITEMS  = 900;
    localparam int QUIET_ITEMS   = 120;    // tail of the random part, no idling
    localparam int SETTLE_CYCLES = DIV_CYCLES + 8;

    // Coordinate extremes and one unit in Q7.8
    localparam logic signed [COORD_W-1:0] C_MAX  = 16'sh7FFF;
    localparam logic signed [COORD_W-1:0] C_MIN  = 16'sh8000;
    localparam logic signed [COORD_W-1:0] C_ZERO = 16'sh0000;
    localparam logic signed [COORD_W-1:0] C_UNIT = 16'sh0100;

    // Clamp bounds of the running sums, widened to 64 bits
    localparam longint VOL_HI   = longint'(VOL_MAX);
    localparam longint VOL_LO   = longint'(VOL_MIN);
    localparam longint AREA_TOP = (longint'(1) << AREA_W) - 1;

    // Running sums of the mesh in flight and the results they lead to
    class mesh_tally;
        longint vol_acc;
        longint area_acc;
        bit     sat_seen;
        int     errors;
        t_res   due_results[$];

        function new();
            vol_acc  = 0;
            area_acc = 0;
            sat_seen = 1'b0;
            errors   = 0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        // Fold one accepted triangle into the sums; queue a result on the last one
        function void add_triangle(t_tri t);
            longint ax, ay, az, bx, by, bz, cx, cy, cz;
            longint det, nz, vsum, asum, mag;
            t_res   r;
            ax = t.p0_x; ay = t.p0_y; az = t.p0_z;
            bx = t.p1_x; by = t.p1_y; bz = t.p1_z;
            cx = t.p2_x; cy = t.p2_y; cz = t.p2_z;

            det = ax * by * cz + bx * cy * az + cx * ay * bz
                - az * by * cx - bz * cy * ax - cz * ay * bx;
            vsum = vol_acc + det;
            if (vsum > VOL_HI) begin
                vsum     = VOL_HI;
                sat_seen = 1'b1;
            end else if (vsum < VOL_LO) begin
                vsum     = VOL_LO;
                sat_seen = 1'b1;
            end
            vol_acc = vsum;

            nz = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
            if (nz > 0) begin
                asum = area_acc + nz;
                if (asum > AREA_TOP) begin
                    asum     = AREA_TOP;
                    sat_seen = 1'b1;
                end
                area_acc = asum;
            end

            if (t.final_triangle) begin
                mag              = (vol_acc < 0) ? -vol_acc : vol_acc;
                r.mesh_volume    = MESH_VOL_W'(mag / 6);
                r.projected_area = PROJ_AREA_W'(area_acc / 2);
                r.saturated      = sat_seen;
                due_results.push_back(r);
                vol_acc  = 0;
                area_acc = 0;
                sat_seen = 1'b0;
            end
        endfunction

        task check_result(t_res got);
            t_res want;
            if (due_results.size() == 0) begin
                report("result with nothing due");
                return;
            end
            want = due_results.pop_front();
            if (got.mesh_volume !== want.mesh_volume)
                report($sformatf("mesh_volume %0d, expected %0d",
                                 got.mesh_volume, want.mesh_volume));
            if (got.projected_area !== want.projected_area)
                report($sformatf("projected_area %0d, expected %0d",
                                 got.projected_area, want.projected_area));
            if (got.saturated !== want.saturated)
                report($sformatf("saturated %0b, expected %0b",
                                 got.saturated, want.saturated));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    mvpa_tri_if tri_if ();
    mvpa_res_if res_if ();

    mesh_tally tally = new();

    // Written by the stimulus process only; read by the receiver
    bit idle_enable   = 1'b1;
    int hold_requests = 0;

    int stall_cycles  = 0;
    int items_sent    = 0;

    mesh_volume_and_projected_area_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tri   (tri_if),
        .o_res   (res_if)
    );

    always #5 i_clk = ~i_clk;

    // Watch both channels at the rising edge: fold inputs, check results,
    // and give up when nothing has moved for too long.
    always @(posedge i_clk) begin
        bit moved;
        moved = 1'b0;
        if (i_rst_n === 1'b1) begin
            if (tri_if.valid && tri_if.ready) begin
                tally.add_triangle(tri_if.payload);
                moved = 1'b1;
            end
            if (res_if.valid && res_if.ready) begin
                tally.check_result(res_if.payload);
                moved = 1'b1;
            end
            if (moved)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAIL mesh_volume_and_projected_area_unit");
                $finish;
            end
        end
    end

    // Result receiver: random bursts of back-pressure, plus one long hold-off
    // whenever the stimulus asks for one.
    initial begin
        int burst;
        int holds_served;
        burst        = 0;
        holds_served = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                burst        = LONG_HOLD;
            end else if (burst == 0 && idle_enable && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 5);
            end
            if (burst > 0) begin
                res_if.ready = 1'b0;
                burst--;
            end else begin
                res_if.ready = 1'b1;
            end
        end
    end

    function automatic t_tri tri_of(
        logic signed [COORD_W-1:0] ax, logic signed [COORD_W-1:0] ay,
        logic signed [COORD_W-1:0] az, logic signed [COORD_W-1:0] bx,
        logic signed [COORD_W-1:0] by, logic signed [COORD_W-1:0] bz,
        logic signed [COORD_W-1:0] cx, logic signed [COORD_W-1:0] cy,
        logic signed [COORD_W-1:0] cz, bit last);
        t_tri t;
        t.p0_x = ax; t.p0_y = ay; t.p0_z = az;
        t.p1_x = bx; t.p1_y = by; t.p1_z = bz;
        t.p2_x = cx; t.p2_y = cy; t.p2_z = cz;
        t.final_triangle = last;
        return t;
    endfunction

    // Mostly full-range values, with a share of extremes and small offsets
    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return C_MAX;
            1:       return C_MIN;
            2:       return C_ZERO;
            3, 4:    return COORD_W'($urandom_range(0, 1023)) - 16'sd512;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic t_tri rand_tri(bit last);
        return tri_of(rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord(), last);
    endfunction

    // Offer one triangle from a falling edge and hold it until its transfer;
    // return on the following falling edge.
    task send_tri(t_tri t);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            tri_if.valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        tri_if.valid   = 1'b1;
        tri_if.payload = t;
        do @(posedge i_clk); while (!tri_if.ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    task send_copies(t_tri t, int count);
        repeat (count) send_tri(t);
    endtask

    // One mesh of random triangles; a noisy mesh scatters last flags at random
    task send_mesh(int len, bit noisy);
        for (int i = 0; i < len; i++)
            send_tri(rand_tri(noisy ? ($urandom_range(0, 3) == 0) : (i == len - 1)));
    endtask

    // Lower valid and pause until every due result has come back
    task wait_drain();
        tri_if.valid = 1'b0;
        while (tally.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        t_tri vol_up, vol_down, area_big, zero_last;
        int   len;

        vol_up    = tri_of(C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MAX,
                           C_MAX, C_MAX, C_MIN, 1'b0);
        vol_down  = tri_of(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MIN,
                           C_MAX, C_MIN, C_MAX, 1'b0);
        area_big  = tri_of(C_MIN, C_MIN, C_ZERO, C_MAX, C_MIN, C_ZERO,
                           C_MIN, C_MAX, C_ZERO, 1'b0);
        zero_last = tri_of(C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO,
                           C_ZERO, C_ZERO, C_ZERO, 1'b1);

        // Drive every input from time zero, hold reset, then release it
        tri_if.valid   = 1'b0;
        tri_if.payload = '0;
        i_rst_n        = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: empty triangle, the largest determinant of each sign,
        // the largest positive cross z, a reversed winding that adds no area,
        // all-minimum and all-maximum vertices
        send_tri(zero_last);
        send_tri(tri_of(C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MAX,
                        C_MAX, C_MAX, C_MIN, 1'b1));
        send_tri(tri_of(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MIN,
                        C_MAX, C_MIN, C_MAX, 1'b1));
        send_tri(tri_of(C_MIN, C_MIN, C_ZERO, C_MAX, C_MIN, C_ZERO,
                        C_MIN, C_MAX, C_ZERO, 1'b1));
        send_tri(tri_of(C_MIN, C_MIN, C_UNIT, C_MIN, C_MAX, C_UNIT,
                        C_MAX, C_MIN, C_UNIT, 1'b1));
        send_tri(tri_of(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                        C_MIN, C_MIN, C_MIN, 1'b1));
        send_tri(tri_of(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                        C_MAX, C_MAX, C_MAX, 1'b1));
        // Unit tetrahedron, outward winding: the last face carries its own
        // contribution into the result
        send_tri(tri_of(C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_UNIT, C_ZERO,
                        C_UNIT, C_ZERO, C_ZERO, 1'b0));
        send_tri(tri_of(C_ZERO, C_ZERO, C_ZERO, C_UNIT, C_ZERO, C_ZERO,
                        C_ZERO, C_ZERO, C_UNIT, 1'b0));
        send_tri(tri_of(C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_UNIT,
                        C_ZERO, C_UNIT, C_ZERO, 1'b0));
        send_tri(tri_of(C_UNIT, C_ZERO, C_ZERO, C_ZERO, C_UNIT, C_ZERO,
                        C_ZERO, C_ZERO, C_UNIT, 1'b1));
        // Mixed mesh: one triangle adds area, its reverse and the volume triangle add none
        send_tri(area_big);
        send_tri(tri_of(C_MIN, C_MAX, C_ZERO, C_MAX, C_MIN, C_ZERO,
                        C_MIN, C_MIN, C_ZERO, 1'b0));
        send_tri(vol_down);
        send_tri(rand_tri(1'b1));
        wait_drain();

        // Short meshes streamed back to back: step the volume up and back
        // down, pile up area, then one more mesh straight after
        idle_enable = 1'b0;
        send_copies(vol_up, 8);
        send_copies(vol_down, 3);
        send_tri(zero_last);
        send_copies(area_big, 6);
        send_tri(zero_last);
        send_tri(vol_up);
        send_tri(zero_last);
        idle_enable = 1'b1;
        wait_drain();

        // Pressure: hold the receiver off while short meshes keep coming, so
        // the queue fills and the input stalls; then wait for all results
        hold_requests++;
        idle_enable = 1'b0;
        repeat (40) send_mesh($urandom_range(1, 3), 1'b0);
        idle_enable = 1'b1;
        wait_drain();

        // Random meshes, mostly well formed, a few with scattered last flags;
        // the tail runs without any idling
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent >= RANDOM_ITEMS - QUIET_ITEMS)
                idle_enable = 1'b0;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                              : $urandom_range(1, 8);
            send_mesh(len, $urandom_range(0, 9) == 0);
        end
        // Close any mesh left open by a noisy sequence
        send_tri(rand_tri(1'b1));

        wait_drain();
        repeat (2 * DIV_CYCLES) @(negedge i_clk);
        if (tally.errors == 0 && tally.pending() == 0)
            $display("PASS mesh_volume_and_projected_area_unit");
        else
            $display("FAIL mesh_volume_and_projected_area_unit");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/mvpa_pkg.sv
rtl/core/mvpa_if.sv
rtl/core/mvpa_front.sv
rtl/core/mvpa_queue.sv
rtl/core/mvpa_back.sv
rtl/core/mesh_volume_and_projected_area_unit.sv
rtl/core/mvpa_checker.sv
tb/mesh_volume_and_projected_area_unit_tb.sv
